@@ src/rrts_pkg.sv @@
// rrts_pkg: shared types and constants of the round-robin task scheduler
// used by every module under src, no dependencies
package rrts_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam logic [4:0] FGPRIO  = 5'd2;
  localparam logic [4:0] BGPRIO  = 5'd1;
  localparam logic [4:0] MAXPRIO = 5'd30;

  // request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_KILL  = 3'd2;
  localparam logic [2:0] REQ_BLOCK = 3'd3;
  localparam logic [2:0] REQ_UNBLK = 3'd4;
  localparam logic [2:0] REQ_NICE  = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FG  = 2'd0;
  localparam logic [1:0] CFG_BG  = 2'd1;
  localparam logic [1:0] CFG_MAX = 2'd2;

  typedef enum logic [1:0] {
    C_FREE    = 2'd0,
    C_READY   = 2'd1,
    C_BLOCKED = 2'd2,
    C_KILLED  = 2'd3
  } cond_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [15:0] parent_id;
    logic [4:0]  prio;
    cond_t       cond;
    logic [63:0] context_value;
    logic        foreground;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] target_id;
    logic [63:0] context_value;
    logic        want_foreground;
    logic [5:0]  new_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [63:0] run_context;
    logic        switched;
    logic        idle;
  } res_t;

  typedef struct packed {
    logic [4:0] fg_priority;
    logic [4:0] bg_priority;
    logic [4:0] max_priority;
  } cfg_t;

endpackage

@@ src/rrts_slot_mem.sv @@
// rrts_slot_mem: task table, one synchronous memory of slot records
// with per-slot valid bits so that unwritten slots read as free; uses rrts_pkg
module rrts_slot_mem import rrts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] raddr,
  output slot_rec_t        rdata,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  slot_rec_t        wdata
);

  slot_rec_t mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld;
  slot_rec_t rd_q;
  logic vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read-during-write to the same slot returns the new record
    if (we && waddr == raddr) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= (we && waddr == raddr) ? 1'b1 : vld[raddr];
    end
  end

  always_comb begin
    rdata = rd_q;
    if (!vld_q) begin
      rdata.cond = C_FREE;
    end
  end

endmodule

@@ src/rrts_queue_mem.sv @@
// rrts_queue_mem: run queue storage, circular buffer of slot numbers
// one write and one registered read per cycle; uses rrts_pkg
module rrts_queue_mem import rrts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] raddr,
  output logic [IDX_W-1:0] rdata,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [IDX_W-1:0] wdata
);

  logic [IDX_W-1:0] mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/rrts_ctrl.sv @@
// rrts_ctrl: request sequencer, reads, modifies and writes back the task
// table and run queue; uses rrts_pkg, rrts_slot_mem, rrts_queue_mem
module rrts_ctrl import rrts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int IDX_W = $clog2(MAX_TASKS),
  localparam int CNT_W = IDX_W + 1
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_TK_RUN   = 17'h00002,
    S_TK_WAKE  = 17'h00004,
    S_TK_FREE  = 17'h00008,
    S_POP_INIT = 17'h00010,
    S_POP_HEAD = 17'h00020,
    S_POP_CHK  = 17'h00040,
    S_ADD_SCAN = 17'h00080,
    S_ADD_PAR  = 17'h00100,
    S_ADD_BLK  = 17'h00200,
    S_FIND_R   = 17'h00400,
    S_FIND_S   = 17'h00800,
    S_SET      = 17'h01000,
    S_NICE     = 17'h02000,
    S_REQ_FIN  = 17'h04000,
    S_EMIT     = 17'h08000,
    S_SPARE    = 17'h10000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

  state_t state, state_next, ret, ret_next;
  req_t req, req_next;
  res_t res_next;
  slot_rec_t rd, hold, hold_next, wdata;
  logic [IDX_W-1:0] sa, sa_next, fslot, fslot_next, waddr;
  logic [IDX_W-1:0] head, head_next, tail, tail_next, qrd;
  logic [IDX_W-1:0] running_slot, running_slot_next, was_slot, was_slot_next;
  logic [CNT_W-1:0] count, count_next, nleft, nleft_next;
  logic [15:0] fid, fid_next, next_id, next_id_next, nid_inc;
  logic [4:0] ticks, ticks_next;
  logic running_valid, running_valid_next, was_valid, was_valid_next;
  logic fnd, fnd_next, we, push_en, pop_en, add_fg;
  logic [IDX_W-1:0] push_slot;
  logic [15:0] add_parent;
  cond_t want_cond;

  rrts_slot_mem #(.MAX_TASKS(MAX_TASKS)) u_slot_mem (
    .clk(clk), .rst(rst), .raddr(sa_next), .rdata(rd),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  rrts_queue_mem #(.MAX_TASKS(MAX_TASKS)) u_queue_mem (
    .clk(clk), .raddr(head_next), .rdata(qrd),
    .we(push_en && count < FULL_CNT), .waddr(tail), .wdata(push_slot)
  );

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign nid_inc   = next_id + 16'd1;
  assign add_fg    = req.want_foreground & (~running_valid | rd.foreground);
  assign add_parent = running_valid ? rd.task_id : 16'd0;

  always_comb begin
    unique case (req.req_type)
      REQ_KILL:  want_cond = C_KILLED;
      REQ_BLOCK: want_cond = C_BLOCKED;
      default:   want_cond = C_READY;
    endcase
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    req_next = req;
    res_next = res;
    hold_next = hold;
    sa_next = sa;
    fslot_next = fslot;
    running_slot_next = running_slot;
    running_valid_next = running_valid;
    was_slot_next = was_slot;
    was_valid_next = was_valid;
    nleft_next = nleft;
    fid_next = fid;
    next_id_next = next_id;
    ticks_next = ticks;
    fnd_next = fnd;
    we = 1'b0;
    waddr = sa;
    wdata = rd;
    push_en = 1'b0;
    push_slot = running_slot;
    pop_en = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next = in_req;
          res_next = '0;
          was_valid_next = running_valid;
          was_slot_next = running_slot;
          fid_next = in_req.target_id;
          sa_next = running_slot;
          unique case (in_req.req_type)
            REQ_TICK: begin
              state_next = running_valid ? S_TK_RUN : S_POP_INIT;
            end
            REQ_ADD: begin
              if (in_req.context_value == 64'd0) begin
                res_next.status = ST_REJECT;
                res_next.idle = ~running_valid;
                state_next = S_EMIT;
              end else begin
                sa_next = '0;
                state_next = S_ADD_SCAN;
              end
            end
            REQ_KILL, REQ_BLOCK, REQ_UNBLK: begin
              ret_next = S_SET;
              state_next = S_FIND_R;
            end
            REQ_NICE: begin
              if (in_req.target_id == 16'd0) begin
                ticks_next = '0;
                state_next = S_REQ_FIN;
              end else begin
                ret_next = S_NICE;
                state_next = S_FIND_R;
              end
            end
            default: begin
              res_next.status = ST_REJECT;
              state_next = S_REQ_FIN;
            end
          endcase
        end
      end

      S_TK_RUN: begin
        if (rd.cond == C_READY && ticks != 5'd0) begin
          ticks_next = ticks - 5'd1;
          res_next.result_id = rd.task_id;
          res_next.run_context = req.context_value;
          state_next = S_EMIT;
        end else begin
          hold_next = rd;
          hold_next.context_value = req.context_value;
          we = 1'b1;
          waddr = running_slot;
          wdata = hold_next;
          if (rd.cond != C_KILLED) begin
            push_en = 1'b1;
            running_valid_next = 1'b0;
            state_next = S_POP_INIT;
          end else if (rd.parent_id != 16'd0) begin
            // running check in the lookup still sees this killed entry
            fid_next = rd.parent_id;
            ret_next = S_TK_WAKE;
            state_next = S_FIND_R;
          end else begin
            state_next = S_TK_FREE;
          end
        end
      end

      S_TK_WAKE: begin
        if (fnd && rd.cond == C_BLOCKED) begin
          we = 1'b1;
          wdata.cond = C_READY;
        end
        state_next = S_TK_FREE;
      end

      S_TK_FREE: begin
        we = 1'b1;
        waddr = running_slot;
        wdata = hold;
        wdata.cond = C_FREE;
        running_valid_next = 1'b0;
        state_next = S_POP_INIT;
      end

      S_POP_INIT: begin
        nleft_next = count;
        state_next = S_POP_HEAD;
      end

      S_POP_HEAD: begin
        if (nleft == '0) begin
          running_slot_next = '0;
          ticks_next = '0;
          res_next.idle = 1'b1;
          state_next = S_EMIT;
        end else begin
          pop_en = 1'b1;
          sa_next = qrd;
          nleft_next = nleft - CNT_W'(1);
          state_next = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        case (rd.cond)
          C_READY: begin
            running_slot_next = sa;
            running_valid_next = 1'b1;
            ticks_next = rd.prio;
            res_next.result_id = rd.task_id;
            res_next.run_context = rd.context_value;
            res_next.switched = ~was_valid | (was_slot != sa);
            state_next = S_EMIT;
          end
          C_BLOCKED: begin
            push_en = 1'b1;
            push_slot = sa;
            state_next = S_POP_HEAD;
          end
          default: begin
            we = 1'b1;
            wdata.cond = C_FREE;
            state_next = S_POP_HEAD;
          end
        endcase
      end

      S_ADD_SCAN: begin
        if (rd.cond == C_FREE && count < FULL_CNT) begin
          fslot_next = sa;
          sa_next = running_slot;
          state_next = S_ADD_PAR;
        end else if (rd.cond == C_FREE || sa == LAST_IDX) begin
          res_next.status = ST_REJECT;
          res_next.idle = ~running_valid;
          state_next = S_EMIT;
        end else begin
          sa_next = sa + IDX_W'(1);
        end
      end

      S_ADD_PAR: begin
        we = 1'b1;
        waddr = fslot;
        wdata.task_id = next_id;
        wdata.parent_id = add_parent;
        wdata.prio = add_fg ? cfg.fg_priority : cfg.bg_priority;
        wdata.cond = C_READY;
        wdata.context_value = req.context_value;
        wdata.foreground = add_fg;
        push_en = 1'b1;
        push_slot = fslot;
        next_id_next = (nid_inc == 16'd0) ? 16'd1 : nid_inc;
        res_next.result_id = next_id;
        res_next.idle = ~running_valid;
        if (add_parent != 16'd0 && add_fg) begin
          // foreground child blocks its parent
          fid_next = add_parent;
          ret_next = S_ADD_BLK;
          state_next = S_FIND_R;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_ADD_BLK: begin
        if (fnd && rd.cond != C_KILLED && rd.cond != C_BLOCKED) begin
          we = 1'b1;
          wdata.cond = C_BLOCKED;
        end
        state_next = S_EMIT;
      end

      S_FIND_R: begin
        if (running_valid && rd.cond != C_FREE && rd.task_id == fid) begin
          fnd_next = 1'b1;
          state_next = ret;
        end else begin
          sa_next = '0;
          state_next = S_FIND_S;
        end
      end

      S_FIND_S: begin
        if (rd.cond != C_FREE && rd.task_id == fid) begin
          fnd_next = 1'b1;
          state_next = ret;
        end else if (sa == LAST_IDX) begin
          fnd_next = 1'b0;
          state_next = ret;
        end else begin
          sa_next = sa + IDX_W'(1);
        end
      end

      S_SET: begin
        if (!fnd || rd.cond == C_KILLED) begin
          res_next.status = ST_UNKNOWN;
        end else if (rd.cond == want_cond) begin
          res_next.status = ST_SAME;
        end else begin
          we = 1'b1;
          wdata.cond = want_cond;
        end
        sa_next = running_slot;
        state_next = S_REQ_FIN;
      end

      S_NICE: begin
        if (!fnd) begin
          res_next.status = ST_UNKNOWN;
        end else if (req.new_priority > {1'b0, cfg.max_priority}) begin
          res_next.status = ST_REJECT;
        end else begin
          we = 1'b1;
          wdata.prio = req.new_priority[4:0];
        end
        sa_next = running_slot;
        state_next = S_REQ_FIN;
      end

      S_REQ_FIN: begin
        res_next.result_id = running_valid ? rd.task_id : 16'd0;
        res_next.idle = ~running_valid;
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // queue pointers
  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    if (pop_en) begin
      head_next = (head == LAST_IDX) ? '0 : head + IDX_W'(1);
      count_next = count - CNT_W'(1);
    end else if (push_en && count < FULL_CNT) begin
      tail_next = (tail == LAST_IDX) ? '0 : tail + IDX_W'(1);
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      sa <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      running_slot <= '0;
      running_valid <= 1'b0;
      ticks <= '0;
      next_id <= 16'd1;
    end else begin
      state <= state_next;
      ret <= ret_next;
      sa <= sa_next;
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
      running_slot <= running_slot_next;
      running_valid <= running_valid_next;
      ticks <= ticks_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    req <= req_next;
    res <= res_next;
    hold <= hold_next;
    fslot <= fslot_next;
    was_slot <= was_slot_next;
    was_valid <= was_valid_next;
    nleft <= nleft_next;
    fid <= fid_next;
    fnd <= fnd_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("run queue count above table size");

  a_idle_matches_run: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.idle == !running_valid)
    else $error("idle flag disagrees with running entry");

  a_switch_not_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.switched |-> !res.idle)
    else $error("switch reported while idle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop_en |-> count != '0)
    else $error("pop from empty run queue");

endmodule

@@ src/round_robin_task_scheduler.sv @@
// Round-robin task scheduler: one transaction in, one result out. Every item is handled
// on its own: a new transaction is taken only once the result of the last one has moved
// into the output register. Kill, block, unblock and nice include a task lookup, an add
// a free slot scan plus a parent lookup, and a task switch a parent lookup plus a visit to
// each run queue entry examined; the task table memory gives one read per cycle. The
// result register lets the next transaction in while a result waits.
// Depends on rrts_pkg and rrts_ctrl.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_id[15:0], context_value[79:16], want_foreground[80], new_priority[86:81]
  input  logic [87:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], result_id[17:2], run_context[81:18], switched[82], idle[83]
  output logic [87:0] m_axis_tdata
);

  cfg_t cfg;
  req_t in_req;
  res_t res;
  logic res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_priority  <= FGPRIO;
      cfg.bg_priority  <= BGPRIO;
      cfg.max_priority <= MAXPRIO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG:  cfg.fg_priority  <= cfg_wdata;
        CFG_BG:  cfg.bg_priority  <= cfg_wdata;
        CFG_MAX: cfg.max_priority <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_req.req_type        = s_axis_tuser;
  assign in_req.target_id       = s_axis_tdata[15:0];
  assign in_req.context_value   = s_axis_tdata[79:16];
  assign in_req.want_foreground = s_axis_tdata[80];
  assign in_req.new_priority    = s_axis_tdata[86:81];

  rrts_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {4'b0000, res.idle, res.switched, res.run_context,
                       res.result_id, res.status};
    end
  end

endmodule
